// File: design/lcps_pkg.sv
// Package of shared types and constants for the LED chaser sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lcps_pkg;

  localparam int unsigned LedW     = 8;
  localparam int unsigned PatW     = 3;
  localparam int unsigned StepW    = 4;
  localparam int unsigned AccW     = 10;
  localparam int unsigned MsW      = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [AccW-1:0] AccMax        = 10'd1023;
  localparam logic [AccW-1:0] FastPeriodRst = 10'd30;
  localparam logic [AccW-1:0] SlowPeriodRst = 10'd100;

  localparam logic [StepW-1:0] StepsLong  = 4'd8;
  localparam logic [StepW-1:0] StepsShort = 4'd4;

  localparam logic [LedW-1:0] LedLowBit   = 8'b00000001;
  localparam logic [LedW-1:0] LedHighBit  = 8'b10000000;
  localparam logic [LedW-1:0] LedUpCentre = 8'h10;
  localparam logic [LedW-1:0] LedLoCentre = 8'h08;
  localparam logic [LedW-1:0] LedUpHalf   = 8'hf0;
  localparam logic [LedW-1:0] LedLoHalf   = 8'h0f;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegFastPeriod = 8'd0;
  localparam logic [CfgIdxW-1:0] RegSlowPeriod = 8'd1;

  typedef enum logic [PatW-1:0] {
    PatWalkLeft  = 3'd0,
    PatWalkRight = 3'd1,
    PatFillLeft  = 3'd2,
    PatFillRight = 3'd3,
    PatBloom     = 3'd4,
    PatClose     = 3'd5
  } pattern_e;

  typedef struct packed {
    logic [PatW-1:0]  pattern;
    logic [StepW-1:0] step;
    logic [AccW-1:0]  accum;
    logic [LedW-1:0]  led;
  } seq_state_t;

  typedef struct packed {
    logic [LedW-1:0] led_bits;
    logic [PatW-1:0] pattern_now;
  } result_t;

endpackage

`default_nettype wire

// File: design/lcps_step.sv
// Next-state logic of the sequencer: one input word advances the pattern state.
`timescale 1ns / 1ps
`default_nettype none

module lcps_step (
  input  lcps_pkg::seq_state_t      state_i,
  input  logic [lcps_pkg::MsW-1:0]  ms_i,
  input  logic [lcps_pkg::AccW-1:0] fast_period_i,
  input  logic [lcps_pkg::AccW-1:0] slow_period_i,
  output lcps_pkg::seq_state_t      state_o
);
  import lcps_pkg::*;

  logic [AccW:0]      sum;
  logic [AccW-1:0]    acc_sat;
  logic [AccW-1:0]    period;
  logic [StepW-1:0]   steps;
  logic [2:0]         i;
  logic [LedW-1:0]    led_next;
  logic               finished;

  assign sum     = {1'b0, state_i.accum} + {{(AccW + 1 - MsW){1'b0}}, ms_i};
  assign acc_sat = sum[AccW] ? AccMax : sum[AccW-1:0];
  assign period  = (state_i.pattern == PatBloom) ? slow_period_i : fast_period_i;
  assign steps   = (state_i.pattern < PatW'(PatBloom)) ? StepsLong : StepsShort;
  assign i       = state_i.step[2:0];
  assign finished = (state_i.pattern > PatW'(PatClose)) || (state_i.step >= steps);

  always_comb begin
    case (state_i.pattern)
      PatWalkLeft:  led_next = LedLowBit << i;
      PatWalkRight: led_next = LedHighBit >> i;
      PatFillLeft:  led_next = state_i.led | (LedLowBit << i);
      PatFillRight: led_next = state_i.led | (LedHighBit >> i);
      PatBloom:     led_next = state_i.led | (LedUpCentre << i) | (LedLoCentre >> i);
      default:      led_next = ((LedUpHalf >> i) & LedUpHalf) | ((LedLoHalf << i) & LedLoHalf);
    endcase
  end

  always_comb begin
    state_o       = state_i;
    state_o.accum = acc_sat;
    if (acc_sat >= period) begin
      state_o.accum = '0;
      if (finished) begin
        state_o.step    = '0;
        state_o.led     = '0;
        state_o.pattern = (state_i.pattern >= PatW'(PatClose)) ? '0 : state_i.pattern + 1'b1;
      end else begin
        state_o.led  = led_next;
        state_o.step = state_i.step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/led_chaser_pattern_sequencer.sv
// Top level of the LED chaser pattern sequencer with its stream and configuration ports.
`timescale 1ns / 1ps
`default_nettype none

// Each input word carries the milliseconds elapsed since the previous word and yields exactly
// one output word with the LED byte and the active pattern index after the update. The whole
// update is one pass of combinational logic from the state registers, so a word is taken in
// every cycle unless the skid register is full, and a two-entry output stage (output register
// plus skid register) lets input continue for one word while the output is stalled. The
// configuration port is always ready; writes to indexes other than 0 and 1 are dropped.
module led_chaser_pattern_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lcps_pkg::InDataW-1:0]    s_axis_tdata,   // [7:0] ms_elapsed
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lcps_pkg::OutDataW-1:0]   m_axis_tdata,   // [7:0] led_bits, [10:8] pattern_now
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lcps_pkg::AccW-1:0]       cfg_data_i
);
  import lcps_pkg::*;

  seq_state_t      state_q, state_d;
  logic [AccW-1:0] fast_q, slow_q;
  logic            out_vld_q, skid_vld_q;
  result_t         out_q, skid_q;
  result_t         res;
  logic            in_acc, out_acc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  lcps_step u_step (
    .state_i       (state_q),
    .ms_i          (s_axis_tdata[MsW-1:0]),
    .fast_period_i (fast_q),
    .slow_period_i (slow_q),
    .state_o       (state_d)
  );

  assign res.led_bits    = state_d.led;
  assign res.pattern_now = state_d.pattern;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      fast_q  <= FastPeriodRst;
      slow_q  <= SlowPeriodRst;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegFastPeriod) begin
          fast_q <= cfg_data_i;
        end else if (cfg_index_i == RegSlowPeriod) begin
          slow_q <= cfg_data_i;
        end
      end
    end
  end

  // The skid register only fills when the output word is held and a new word arrives.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_acc) begin
        out_vld_q  <= skid_vld_q || in_acc;
        skid_vld_q <= 1'b0;
      end else if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_acc) begin
      out_q <= skid_vld_q ? skid_q : res;
    end
    if (out_vld_q && !out_acc && in_acc) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - LedW - PatW){1'b0}}, out_q.pattern_now, out_q.led_bits};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a word while the output register is empty");

  a_pattern_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pattern <= PatW'(PatClose))
    else $error("pattern index out of range");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.step <= StepsLong)
    else $error("step index out of range");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_vld_q) |=> (m_axis_tvalid && m_axis_tdata[LedW-1:0] == state_q.led))
    else $error("accepted word did not reach the output");

endmodule

`default_nettype wire
